// ----- rtl/ovn_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and the cosine blend weight function for the octave value noise unit.
package ovn_pkg;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [10:0] LATTICE_COUNT_RST = 11'd1;
    localparam logic [3:0]  OCTAVE_COUNT_RST  = 4'd1;
    localparam logic [15:0] PERSISTENCE_RST   = 16'd16384;

    localparam int QUO_BITS  = 16;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(QUO_BITS - 1);

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [1:0] {
        REG_LATTICE_COUNT = 2'd0,
        REG_OCTAVE_COUNT  = 2'd1,
        REG_PERSISTENCE   = 2'd2
    } reg_idx_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FETCH,
        ST_BLEND,
        ST_WEIGHT,
        ST_ACCUM,
        ST_NORM,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [10:0] lattice_count;
        logic [3:0]  octave_count;
        logic [15:0] persistence;
    } cfg_t;

    typedef struct packed {
        logic load_write;
        logic eval_start;
        logic scale;
        logic fetch;
        logic blend;
        logic weight;
        logic accum;
        logic norm;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_octave;
        logic div_last;
    } dp_status_t;

    // Raised-cosine weight for the lower half of the blend table, Q0.16.
    function automatic logic [16:0] half_weight(input logic [63:0] j, input int bits);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] term;
        longint      c;
        u    = (PI_Q30 * j) >> bits;
        u2   = (u * u) >> 30;
        term = ONE_Q30;
        c    = longint'(ONE_Q30);
        term = ((term * u2) >> 30) / 64'd2;
        c    = c - longint'(term);
        term = ((term * u2) >> 30) / 64'd12;
        c    = c + longint'(term);
        term = ((term * u2) >> 30) / 64'd30;
        c    = c - longint'(term);
        term = ((term * u2) >> 30) / 64'd56;
        c    = c + longint'(term);
        term = ((term * u2) >> 30) / 64'd90;
        c    = c - longint'(term);
        term = ((term * u2) >> 30) / 64'd132;
        c    = c + longint'(term);
        term = ((term * u2) >> 30) / 64'd182;
        c    = c - longint'(term);
        if (c < 0)
        begin
            c = 0;
        end
        if (c > longint'(ONE_Q30))
        begin
            c = longint'(ONE_Q30);
        end
        return 17'(((ONE_Q30 - 64'(c)) + (64'd1 << 14)) >> 15);
    endfunction

    // The upper half mirrors the lower half about one half.
    function automatic logic [16:0] blend_weight(input logic [63:0] j, input int bits);
        logic [63:0] full;
        full = 64'd1 << bits;
        if (j <= (full >> 1))
        begin
            return half_weight(j, bits);
        end
        return 17'(64'd65536 - 64'(half_weight(full - j, bits)));
    endfunction

endpackage

// ----- rtl/octave_value_noise_1d_unit.sv -----
`timescale 1ns / 1ps
// Top level of the one-dimensional fractal value noise unit with cosine blending.
// A load beat (kind 0) writes one lattice value; loads may follow each other back to back.
// An evaluate beat (kind 1) returns one noise beat: the fraction of the position is scaled
// through the active octaves, each octave passing through table read, blend multiply, weight
// multiplies and accumulate, followed by normalisation through a one-bit-per-cycle divider.
// The next beat is taken in the cycle after the result enters the output register. The input
// side is taken again while a result still waits there. Lattice entries must be loaded before
// they are read; the table has no reset. Registers: lattice count at 0x0, octave count at 0x4,
// persistence (Q1.15) at 0x8; they should be written only while the unit is idle.
module octave_value_noise_1d_unit #(
    parameter int TABLE_DEPTH      = 1024,
    parameter int MAX_OCTAVES      = 8,
    parameter int BLEND_TABLE_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ovn_pkg::APB_AW-1:0] paddr,
    input  logic [ovn_pkg::APB_DW-1:0] pwdata,
    output logic [ovn_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic                       kind,
    input  logic [9:0]                 lattice_index,
    input  logic [15:0]                lattice_value,
    input  logic [31:0]                position,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [15:0]                noise
);

    ovn_pkg::cfg_t       cfg;
    ovn_pkg::dp_cmd_t    cmd;
    ovn_pkg::dp_status_t status;

    ovn_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ovn_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    ovn_datapath #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .MAX_OCTAVES      (MAX_OCTAVES),
        .BLEND_TABLE_BITS (BLEND_TABLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .lattice_index (lattice_index),
        .lattice_value (lattice_value),
        .position      (position),
        .noise         (noise)
    );

endmodule

// ----- rtl/ovn_cfg.sv -----
`timescale 1ns / 1ps
// APB register file holding lattice count, octave count and persistence.
module ovn_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ovn_pkg::APB_AW-1:0]   paddr,
    input  logic [ovn_pkg::APB_DW-1:0]   pwdata,
    output logic [ovn_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output ovn_pkg::cfg_t                cfg
);

    logic [10:0] lattice_count_reg, lattice_count_next;
    logic [3:0]  octave_count_reg, octave_count_next;
    logic [15:0] persistence_reg, persistence_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        lattice_count_next = lattice_count_reg;
        octave_count_next  = octave_count_reg;
        persistence_next   = persistence_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                ovn_pkg::REG_LATTICE_COUNT: lattice_count_next = pwdata[10:0];
                ovn_pkg::REG_OCTAVE_COUNT:  octave_count_next  = pwdata[3:0];
                ovn_pkg::REG_PERSISTENCE:   persistence_next   = pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lattice_count_reg <= ovn_pkg::LATTICE_COUNT_RST;
            octave_count_reg  <= ovn_pkg::OCTAVE_COUNT_RST;
            persistence_reg   <= ovn_pkg::PERSISTENCE_RST;
        end
        else
        begin
            lattice_count_reg <= lattice_count_next;
            octave_count_reg  <= octave_count_next;
            persistence_reg   <= persistence_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ovn_pkg::REG_LATTICE_COUNT: prdata = 32'(lattice_count_reg);
            ovn_pkg::REG_OCTAVE_COUNT:  prdata = 32'(octave_count_reg);
            ovn_pkg::REG_PERSISTENCE:   prdata = 32'(persistence_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.lattice_count = lattice_count_reg;
    assign cfg.octave_count  = octave_count_reg;
    assign cfg.persistence   = persistence_reg;

endmodule

// ----- rtl/ovn_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for loads, the per-octave loop, the divider and the result register handshake.
module ovn_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  kind,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  ovn_pkg::dp_status_t   status,
    output ovn_pkg::dp_cmd_t      cmd
);

    ovn_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ovn_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~result_ready;
        cmd            = '0;
        item_ready     = 1'b0;
        unique case (state_reg)
            ovn_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (kind == ovn_pkg::KIND_EVAL)
                    begin
                        cmd.eval_start = 1'b1;
                        state_next     = ovn_pkg::ST_SCALE;
                    end
                    else
                    begin
                        cmd.load_write = 1'b1;
                    end
                end
            end
            ovn_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ovn_pkg::ST_FETCH;
            end
            ovn_pkg::ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ovn_pkg::ST_BLEND;
            end
            ovn_pkg::ST_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = ovn_pkg::ST_WEIGHT;
            end
            ovn_pkg::ST_WEIGHT:
            begin
                cmd.weight = 1'b1;
                state_next = ovn_pkg::ST_ACCUM;
            end
            ovn_pkg::ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = status.last_octave ? ovn_pkg::ST_NORM : ovn_pkg::ST_FETCH;
            end
            ovn_pkg::ST_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = ovn_pkg::ST_DIVIDE;
            end
            ovn_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ovn_pkg::ST_DONE;
                end
            end
            ovn_pkg::ST_DONE:
            begin
                // The result register may only be overwritten once its beat has gone.
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ovn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ovn_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

// ----- rtl/ovn_datapath.sv -----
`timescale 1ns / 1ps
// Lattice memory, blend table, octave arithmetic, accumulators and bit-serial divider.
module ovn_datapath #(
    parameter int TABLE_DEPTH      = 1024,
    parameter int MAX_OCTAVES      = 8,
    parameter int BLEND_TABLE_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ovn_pkg::cfg_t        cfg,
    input  ovn_pkg::dp_cmd_t     cmd,
    output ovn_pkg::dp_status_t  status,
    input  logic [9:0]           lattice_index,
    input  logic [15:0]          lattice_value,
    input  logic [31:0]          position,
    output logic [15:0]          noise
);

    localparam int AW           = $clog2(TABLE_DEPTH);
    localparam int LW           = $clog2(TABLE_DEPTH + 1);
    localparam int OCW          = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int WL           = 24;
    localparam int WH           = MAX_OCTAVES;
    localparam int WW           = WL + WH;
    localparam int ACCW         = 16 + WW;
    localparam int PW           = 16 + LW;
    localparam int BlendEntries = 1 << BLEND_TABLE_BITS;
    localparam logic [WW-1:0] WInit = WW'(1) << 23;

    // Constant cosine blend table, evaluated at elaboration.
    logic [16:0] blend_rom [BlendEntries];
    for (genvar gi = 0; gi < BlendEntries; gi++)
    begin : g_blend
        localparam logic [16:0] Weight = ovn_pkg::blend_weight(64'(gi), BLEND_TABLE_BITS);
        assign blend_rom[gi] = Weight;
    end

    logic [15:0] lattice_mem [TABLE_DEPTH];

    logic [15:0]        frac_reg, frac_next;
    logic [LW-1:0]      l_reg, l_next;
    logic [OCW-1:0]     oct_last_reg, oct_last_next;
    logic [OCW-1:0]     oct_cnt_reg, oct_cnt_next;
    logic [ovn_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [15:0]        a_reg, b_reg;
    logic [16:0]        bw_reg, bw_next;
    logic signed [34:0] blend_prod_reg, blend_prod_next;
    logic [16+WL-1:0]   pv_lo_reg, pv_lo_next, pp_lo_reg, pp_lo_next;
    logic [16+WH-1:0]   pv_hi_reg, pv_hi_next, pp_hi_reg, pp_hi_next;
    logic [ACCW-1:0]    acc_reg, acc_next;
    logic [WW-1:0]      wsum_reg, wsum_next;
    logic [WW-1:0]      w_reg, w_next;
    logic [WW-1:0]      rem_reg, rem_next;
    logic [15:0]        quo_reg, quo_next;
    logic [15:0]        noise_reg, noise_next;

    logic [31:0]        lc_wide, l_eff_wide, oc_wide, oc_eff_wide, oct_last_wide, idx_wide;
    logic               write_ok;
    logic [LW-1:0]      int_part, int_inc, i2_full;
    logic [AW-1:0]      rd_addr_a, rd_addr_b;
    logic [BLEND_TABLE_BITS-1:0] j_idx;
    logic [PW:0]        dbl, dbl_wrapped;
    logic signed [16:0] diff;
    logic signed [35:0] v_sum;
    logic [15:0]        v;
    logic [WW+16:0]     w_full;
    logic [ACCW-1:0]    num;
    logic [WW:0]        trial, trial_sub;
    logic               ge;

    // Register values outside the useful range are clamped.
    always_comb
    begin
        lc_wide = 32'(cfg.lattice_count);
        if (lc_wide == 32'd0)
        begin
            l_eff_wide = 32'd1;
        end
        else if (lc_wide > 32'(TABLE_DEPTH))
        begin
            l_eff_wide = 32'(TABLE_DEPTH);
        end
        else
        begin
            l_eff_wide = lc_wide;
        end
        oc_wide = 32'(cfg.octave_count);
        if (oc_wide == 32'd0)
        begin
            oc_eff_wide = 32'd1;
        end
        else if (oc_wide > 32'(MAX_OCTAVES))
        begin
            oc_eff_wide = 32'(MAX_OCTAVES);
        end
        else
        begin
            oc_eff_wide = oc_wide;
        end
        oct_last_wide = oc_eff_wide - 32'd1;
    end

    assign idx_wide = 32'(lattice_index);
    assign write_ok = idx_wide < 32'(TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.load_write && write_ok)
        begin
            lattice_mem[idx_wide[AW-1:0]] <= lattice_value;
        end
    end

    // Table addresses of the current octave: the cell and its wrapping neighbour.
    assign int_part  = pos_reg[PW-1:16];
    assign int_inc   = int_part + LW'(1);
    assign i2_full   = (int_inc == l_reg) ? '0 : int_inc;
    assign rd_addr_a = int_part[AW-1:0];
    assign rd_addr_b = i2_full[AW-1:0];
    assign j_idx     = pos_reg[15 -: BLEND_TABLE_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            a_reg <= lattice_mem[rd_addr_a];
            b_reg <= lattice_mem[rd_addr_b];
        end
    end

    // Doubling the position for the next octave leaves the integer part below 2L,
    // so one conditional subtract keeps it reduced modulo L.
    assign dbl         = {pos_reg, 1'b0};
    assign dbl_wrapped = (dbl[PW:16] >= {1'b0, l_reg}) ? dbl - ((PW + 1)'(l_reg) << 16) : dbl;

    // a*(1-w) + b*w is rewritten as a + (b-a)*w, which needs a single multiplier.
    assign diff  = $signed({1'b0, b_reg}) - $signed({1'b0, a_reg});
    assign v_sum = $signed({4'b0, a_reg, 16'b0}) + 36'(blend_prod_reg) + 36'sd32768;
    assign v     = v_sum[31:16];

    assign w_full = (WW + 17)'(pp_lo_reg) + ((WW + 17)'(pp_hi_reg) << WL) + (WW + 17)'(16384);
    assign num    = acc_reg + ACCW'(wsum_reg >> 1);

    // The rounded quotient never exceeds full scale, so sixteen quotient bits suffice.
    assign trial     = {rem_reg, quo_reg[15]};
    assign trial_sub = trial - {1'b0, wsum_reg};
    assign ge        = trial >= {1'b0, wsum_reg};

    always_comb
    begin
        frac_next       = frac_reg;
        l_next          = l_reg;
        oct_last_next   = oct_last_reg;
        oct_cnt_next    = oct_cnt_reg;
        div_cnt_next    = div_cnt_reg;
        pos_next        = pos_reg;
        bw_next         = bw_reg;
        blend_prod_next = blend_prod_reg;
        pv_lo_next      = pv_lo_reg;
        pv_hi_next      = pv_hi_reg;
        pp_lo_next      = pp_lo_reg;
        pp_hi_next      = pp_hi_reg;
        acc_next        = acc_reg;
        wsum_next       = wsum_reg;
        w_next          = w_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        noise_next      = noise_reg;
        if (cmd.eval_start)
        begin
            frac_next     = position[15:0];
            l_next        = l_eff_wide[LW-1:0];
            oct_last_next = oct_last_wide[OCW-1:0];
        end
        if (cmd.scale)
        begin
            pos_next     = PW'(frac_reg) * PW'(l_reg);
            acc_next     = '0;
            wsum_next    = '0;
            w_next       = WInit;
            oct_cnt_next = '0;
        end
        if (cmd.fetch)
        begin
            bw_next  = blend_rom[j_idx];
            pos_next = dbl_wrapped[PW-1:0];
        end
        if (cmd.blend)
        begin
            blend_prod_next = diff * $signed({1'b0, bw_reg});
        end
        if (cmd.weight)
        begin
            pv_lo_next = (16 + WL)'(v) * (16 + WL)'(w_reg[WL-1:0]);
            pv_hi_next = (16 + WH)'(v) * (16 + WH)'(w_reg[WW-1:WL]);
            pp_lo_next = (16 + WL)'(cfg.persistence) * (16 + WL)'(w_reg[WL-1:0]);
            pp_hi_next = (16 + WH)'(cfg.persistence) * (16 + WH)'(w_reg[WW-1:WL]);
            wsum_next  = wsum_reg + w_reg;
        end
        if (cmd.accum)
        begin
            acc_next     = acc_reg + ACCW'(pv_lo_reg) + (ACCW'(pv_hi_reg) << WL);
            w_next       = w_full[15 +: WW];
            oct_cnt_next = oct_cnt_reg + OCW'(1);
        end
        if (cmd.norm)
        begin
            rem_next     = num[ACCW-1:16];
            quo_next     = num[15:0];
            div_cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next     = ge ? trial_sub[WW-1:0] : trial[WW-1:0];
            quo_next     = {quo_reg[14:0], ge};
            div_cnt_next = div_cnt_reg + ovn_pkg::DIV_CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            noise_next = quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            oct_cnt_reg <= oct_cnt_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg       <= frac_next;
        l_reg          <= l_next;
        oct_last_reg   <= oct_last_next;
        pos_reg        <= pos_next;
        bw_reg         <= bw_next;
        blend_prod_reg <= blend_prod_next;
        pv_lo_reg      <= pv_lo_next;
        pv_hi_reg      <= pv_hi_next;
        pp_lo_reg      <= pp_lo_next;
        pp_hi_reg      <= pp_hi_next;
        acc_reg        <= acc_next;
        wsum_reg       <= wsum_next;
        w_reg          <= w_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        noise_reg      <= noise_next;
    end

    assign status.last_octave = (oct_cnt_reg == oct_last_reg);
    assign status.div_last    = (div_cnt_reg == ovn_pkg::DIV_CNT_LAST);
    assign noise              = noise_reg;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the octave value noise unit with queued stimulus and checks.
module testbench;

    localparam int TABLE_DEPTH      = 1024;
    localparam int MAX_OCTAVES      = 8;
    localparam int BLEND_TABLE_BITS = 8;
    localparam int DRAIN_CYCLES     = 64;
    localparam int HOLD_CYCLES      = 400;
    localparam int STALL_LIMIT      = 4000;
    localparam int PHASE_ITEMS      = 330;
    localparam logic [1:0]  UNUSED_REG = 2'd3;
    localparam logic [63:0] PI_FIXED   = 64'd3373259426;
    localparam logic [63:0] UNIT_FIXED = 64'd1 << 30;

    typedef struct packed {
        ovn_pkg::kind_t kind;
        logic [9:0]     lattice_index;
        logic [15:0]    lattice_value;
        logic [31:0]    position;
    } noise_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ovn_pkg::APB_AW-1:0] paddr = '0;
    logic [ovn_pkg::APB_DW-1:0] pwdata = '0;
    wire  [ovn_pkg::APB_DW-1:0] prdata;
    wire         pready;
    logic        item_valid = 1'b0;
    wire         item_ready;
    ovn_pkg::kind_t kind = ovn_pkg::KIND_LOAD;
    logic [9:0]  lattice_index = '0;
    logic [15:0] lattice_value = '0;
    logic [31:0] position = '0;
    wire         result_valid;
    logic        result_ready = 1'b0;
    wire  [15:0] noise;

    // Stimulus side: queue, generator's view of the table and of the registers.
    noise_item_t pending_items[$];
    noise_item_t staged;
    bit          loaded_entries[TABLE_DEPTH];
    logic [10:0] gen_lattice_count = ovn_pkg::LATTICE_COUNT_RST;
    logic [3:0]  gen_octaves = ovn_pkg::OCTAVE_COUNT_RST;
    int          items_queued = 0;
    bit          steady = 1'b0;
    bit          hold_request = 1'b0;

    // Prediction side: own copy of the table, updated on accepted beats, and of the registers.
    logic [15:0] lattice_copy[TABLE_DEPTH];
    logic [10:0] cfg_lattice_count = ovn_pkg::LATTICE_COUNT_RST;
    logic [3:0]  cfg_octaves = ovn_pkg::OCTAVE_COUNT_RST;
    logic [15:0] cfg_persistence = ovn_pkg::PERSISTENCE_RST;
    logic [15:0] expected_noise[$];
    int          items_accepted = 0;
    int          fail_count = 0;
    bit          item_taken = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          stall_cycles = 0;

    octave_value_noise_1d_unit #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .MAX_OCTAVES      (MAX_OCTAVES),
        .BLEND_TABLE_BITS (BLEND_TABLE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .kind          (kind),
        .lattice_index (lattice_index),
        .lattice_value (lattice_value),
        .position      (position),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .noise         (noise)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned effective_count(input logic [10:0] raw);
        if (raw == 0)
        begin
            return 1;
        end
        if (raw > TABLE_DEPTH)
        begin
            return TABLE_DEPTH;
        end
        return 32'(raw);
    endfunction

    function automatic int unsigned effective_octaves(input logic [3:0] raw);
        if (raw == 0)
        begin
            return 1;
        end
        if (raw > MAX_OCTAVES)
        begin
            return MAX_OCTAVES;
        end
        return 32'(raw);
    endfunction

    // Raised-cosine weight in Q0.16; the upper half of the table mirrors the lower half.
    function automatic logic [16:0] cosine_weight(input int unsigned j);
        int unsigned full;
        int unsigned jj;
        bit          mirror;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] term;
        longint      c;
        logic [16:0] half;
        full   = 1 << BLEND_TABLE_BITS;
        mirror = (j > (full >> 1));
        jj     = mirror ? full - j : j;
        u      = (PI_FIXED * 64'(jj)) >> BLEND_TABLE_BITS;
        u2     = (u * u) >> 30;
        term   = UNIT_FIXED;
        c      = longint'(UNIT_FIXED);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * u2) >> 30;
            term = term / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
            begin
                c = c - longint'(term);
            end
            else
            begin
                c = c + longint'(term);
            end
        end
        if (c < 0)
        begin
            c = 0;
        end
        if (c > longint'(UNIT_FIXED))
        begin
            c = longint'(UNIT_FIXED);
        end
        half = 17'(((UNIT_FIXED - 64'(c)) + (64'd1 << 14)) >> 15);
        return mirror ? 17'(17'd65536 - half) : half;
    endfunction

    function automatic logic [15:0] predict_noise(input logic [31:0] pos);
        int unsigned span;
        int unsigned octaves;
        int unsigned i1;
        int unsigned i2;
        int unsigned j;
        logic [63:0] frac;
        logic [63:0] p;
        logic [63:0] bw;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] v;
        logic [63:0] acc;
        logic [63:0] wsum;
        logic [63:0] w;
        logic [63:0] res;
        span    = effective_count(cfg_lattice_count);
        octaves = effective_octaves(cfg_octaves);
        frac    = 64'(pos[15:0]);
        acc     = 0;
        wsum    = 0;
        w       = 64'd1 << 23;
        for (int k = 0; k < octaves; k++)
        begin
            p    = (frac * 64'(span)) << k;
            i1   = int'((p >> 16) % 64'(span));
            i2   = (i1 + 1) % span;
            j    = int'((p & 64'hFFFF) >> (16 - BLEND_TABLE_BITS));
            bw   = 64'(cosine_weight(j));
            a    = 64'(lattice_copy[i1]);
            b    = 64'(lattice_copy[i2]);
            v    = (a * (64'd65536 - bw) + b * bw + 64'd32768) >> 16;
            acc  = acc + v * w;
            wsum = wsum + w;
            w    = (w * 64'(cfg_persistence) + 64'd16384) >> 15;
        end
        res = (acc + (wsum >> 1)) / wsum;
        if (res > 64'd65535)
        begin
            res = 64'd65535;
        end
        return res[15:0];
    endfunction

    function automatic void push_item(input ovn_pkg::kind_t k, input logic [9:0] idx,
                                      input logic [15:0] val, input logic [31:0] pos);
        noise_item_t it;
        it.kind          = k;
        it.lattice_index = idx;
        it.lattice_value = val;
        it.position      = pos;
        pending_items.push_back(it);
        items_queued++;
        if (k == ovn_pkg::KIND_LOAD)
        begin
            loaded_entries[idx] = 1'b1;
        end
    endfunction

    // Queues a load for every entry that the evaluation will read and has not been written yet, then the evaluation.
    function automatic int queue_eval(input logic [31:0] pos);
        int unsigned span;
        int unsigned octaves;
        int unsigned i1;
        int unsigned i2;
        logic [63:0] p;
        int          made;
        span    = effective_count(gen_lattice_count);
        octaves = effective_octaves(gen_octaves);
        made    = 0;
        for (int k = 0; k < octaves; k++)
        begin
            p  = (64'(pos[15:0]) * 64'(span)) << k;
            i1 = int'((p >> 16) % 64'(span));
            i2 = (i1 + 1) % span;
            if (!loaded_entries[i1])
            begin
                push_item(ovn_pkg::KIND_LOAD, 10'(i1), 16'($urandom), $urandom);
                made++;
            end
            if (!loaded_entries[i2])
            begin
                push_item(ovn_pkg::KIND_LOAD, 10'(i2), 16'($urandom), $urandom);
                made++;
            end
        end
        push_item(ovn_pkg::KIND_EVAL, 10'($urandom), 16'($urandom), pos);
        return made + 1;
    endfunction

    task automatic write_reg(input logic [1:0] reg_sel, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        unique case (reg_sel)
            ovn_pkg::REG_LATTICE_COUNT: gen_lattice_count = data[10:0];
            ovn_pkg::REG_OCTAVE_COUNT:  gen_octaves = data[3:0];
            default: ;
        endcase
    endtask

    // Waits until every item is taken and every noise beat has come, then lets the unit finish.
    task automatic settle();
        while (items_accepted != items_queued || expected_noise.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [31:0] lc, input logic [31:0] oc,
                             input logic [31:0] pers);
        settle();
        write_reg(ovn_pkg::REG_LATTICE_COUNT, lc);
        write_reg(ovn_pkg::REG_OCTAVE_COUNT, oc);
        write_reg(ovn_pkg::REG_PERSISTENCE, pers);
    endtask

    task automatic random_phase(input logic [31:0] lc, input logic [31:0] oc,
                                input logic [31:0] pers, input bit calm, input bit squeeze);
        int          made;
        logic [31:0] pos;
        logic [9:0]  idx;
        configure(lc, oc, pers);
        steady = calm;
        if (squeeze)
        begin
            hold_request = 1'b1;
        end
        made = 0;
        while (made < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 20)
            begin
                idx = 10'($urandom);
                push_item(ovn_pkg::KIND_LOAD, idx, 16'($urandom), $urandom);
                made++;
            end
            else
            begin
                pos = $urandom;
                if ($urandom_range(7) == 0)
                begin
                    pos[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
                made += queue_eval(pos);
            end
        end
    endtask

    initial
    begin
        int discard;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one lattice entry, one octave.
        push_item(ovn_pkg::KIND_LOAD, 10'd0, 16'hFFFF, 32'h0);
        discard = queue_eval(32'h0000_0000);
        discard = queue_eval(32'hFFFF_FFFF);
        discard = queue_eval(32'h0001_8000);

        // Zero counts fall back to one; zero persistence; an unknown register is ignored.
        configure(32'd0, 32'd0, 32'd0);
        write_reg(UNUSED_REG, 32'hFFFF_FFFF);
        push_item(ovn_pkg::KIND_LOAD, 10'd0, 16'h0000, 32'hFFFF_FFFF);
        discard = queue_eval(32'h1234_5678);
        push_item(ovn_pkg::KIND_LOAD, 10'd1023, 16'hFFFF, 32'h0);
        discard = queue_eval(32'hFFFF_0001);

        // Two entries, octave count above the maximum, largest persistence; the fractions pick
        // blend indexes zero, one, one half and the top.
        configure(32'd2, 32'd15, 32'd65535);
        push_item(ovn_pkg::KIND_LOAD, 10'd1, 16'hFFFF, 32'h0);
        push_item(ovn_pkg::KIND_LOAD, 10'd0, 16'h0000, 32'h0);
        discard = queue_eval(32'h0000_0000);
        discard = queue_eval(32'h0000_0080);
        discard = queue_eval(32'h0000_4000);
        discard = queue_eval(32'h0000_7F80);
        discard = queue_eval(32'hFFFF_FFFF);

        random_phase(32'd2047, 32'd8, 32'd16384, 1'b0, 1'b0);
        random_phase(32'd1, 32'd1, 32'd0, 1'b0, 1'b0);
        random_phase($urandom_range(1, 1024), $urandom_range(1, 8), $urandom, 1'b1, 1'b0);
        random_phase(32'd1024, 32'd8, 32'd65535, 1'b0, 1'b1);
        random_phase($urandom_range(2047), $urandom_range(15), $urandom, 1'b0, 1'b0);
        random_phase(32'd3, 32'd4, 32'd32768, 1'b0, 1'b0);

        settle();
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Item driver: a beat stays on the port until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 33))
            begin
                staged = pending_items.pop_front();
                kind          <= staged.kind;
                lattice_index <= staged.lattice_index;
                lattice_value <= staged.lattice_value;
                position      <= staged.position;
                item_valid    <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off so that the unit backs up into its input.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            result_ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
        begin
            result_ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    // Monitor: tracks register writes and item beats, predicts, and checks noise beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_taken <= item_valid && item_ready;
            if (psel && penable && pwrite && pready)
            begin
                unique case (paddr[3:2])
                    ovn_pkg::REG_LATTICE_COUNT: cfg_lattice_count = pwdata[10:0];
                    ovn_pkg::REG_OCTAVE_COUNT:  cfg_octaves = pwdata[3:0];
                    ovn_pkg::REG_PERSISTENCE:   cfg_persistence = pwdata[15:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                items_accepted++;
                if (kind == ovn_pkg::KIND_LOAD)
                begin
                    lattice_copy[lattice_index] = lattice_value;
                end
                else
                begin
                    expected_noise.push_back(predict_noise(position));
                end
            end
            if (result_valid && result_ready)
            begin
                if (expected_noise.size() == 0)
                begin
                    $error("noise beat with no evaluation outstanding: actual %0d", noise);
                    fail_count++;
                end
                else if (noise !== expected_noise[0])
                begin
                    $error("noise mismatch: expected %0d, actual %0d", expected_noise[0], noise);
                    fail_count++;
                    void'(expected_noise.pop_front());
                end
                else
                begin
                    void'(expected_noise.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
